// ===== rtl/tle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tle_pkg
// Shared types, codes and constants of the terminal line editor.
// ============================================================================
package tle_pkg;

   // line and result limits
   localparam int LINE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS    = 48;
   localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);

   // character widths
   localparam int CHAR_W = 7;
   localparam int BYTE_W = 8;

   // echo bytes
   localparam logic [BYTE_W-1:0] BS_BYTE    = 8'h08;
   localparam logic [BYTE_W-1:0] SP_BYTE    = 8'h20;
   localparam logic [BYTE_W-1:0] CARET_BYTE = 8'h5E;
   localparam logic [CHAR_W-1:0] SP_CHAR    = 7'h20;
   localparam logic [CHAR_W-1:0] TAB_CHAR   = 7'h09;

   // control register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_ERASE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KILL      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WORD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIT_NEXT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REPRINT   = 3'd4;

   // control register reset values
   localparam logic [CHAR_W-1:0] ERASE_RST    = 7'd127;
   localparam logic [CHAR_W-1:0] KILL_RST     = 7'd21;
   localparam logic [CHAR_W-1:0] WORD_RST     = 7'd23;
   localparam logic [CHAR_W-1:0] LIT_NEXT_RST = 7'd22;
   localparam logic [CHAR_W-1:0] REPRINT_RST  = 7'd18;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_ECHO,
      S_CARET,
      S_LIT_BS,
      S_W_RD,
      S_W_CHK,
      S_RUB1,
      S_RUB2,
      S_RUB3,
      S_P_BS,
      S_P_CH
   } state_type;

   // rubout flavor
   typedef enum logic [1:0] {
      M_ERASE,
      M_KILL,
      M_WORD
   } mode_type;

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == SP_CHAR) || (c == TAB_CHAR);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tle_line_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tle_line_ram
// Line buffer: one write port, one read port, registered read data.
// ============================================================================
module tle_line_ram
   import tle_pkg::*;
#(
   parameter int LINE_DEPTH = LINE_DEPTH_DEF,
   localparam int IDX_W = $clog2(LINE_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire logic [CHAR_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output logic      [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem_ff [LINE_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/terminal_line_editor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// terminal_line_editor_top
// Canonical line editing of typed characters with echo generation.
// ============================================================================
// One request is taken at a time; req_ready rises again as soon as the last
// echo byte of the previous request sits in the output register. Echo bytes
// leave at most one per cycle when rsp_ready stays high. Every request is
// taken in idle; then a plain character sends its echo and an erase sends
// backspace, space, backspace; kill sends those three per stored character; word
// erase spends a line-buffer read and a test per trailing blank, plus a read
// and a test to turn into the word, then backspace, space, backspace per word
// character; reprint sends a backspace per stored character, then each one;
// literal next sends a caret and a backspace. The line buffer is a synchronous
// memory with registered read data, hence the read step per blank in word erase.
// At most MAX_RESULTS bytes go out per request; beyond that the line state
// still updates silently.
// ============================================================================
module terminal_line_editor_top
   import tle_pkg::*;
#(
   parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [BYTE_W-1:0]    req_char_in,
   // echo channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [BYTE_W-1:0]    rsp_echo_byte,
   output logic                      rsp_last_echo,
   // control registers
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CHAR_W-1:0]    csr_wdata
);

   localparam int IDX_W = $clog2(LINE_DEPTH);
   localparam int CNT_W = $clog2(LINE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LINE_DEPTH);
   localparam logic [RES_CNT_W-1:0] RES_MAX = RES_CNT_W'(MAX_RESULTS);

   // control registers
   logic [CHAR_W-1:0] erase_ff, kill_ff, word_ff, lit_next_ff, reprint_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_ff    <= ERASE_RST;
         kill_ff     <= KILL_RST;
         word_ff     <= WORD_RST;
         lit_next_ff <= LIT_NEXT_RST;
         reprint_ff  <= REPRINT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_ERASE:    erase_ff    <= csr_wdata;
            REG_KILL:     kill_ff     <= csr_wdata;
            REG_WORD:     word_ff     <= csr_wdata;
            REG_LIT_NEXT: lit_next_ff <= csr_wdata;
            REG_REPRINT:  reprint_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer state
   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  lit_ff, lit_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic [RES_CNT_W-1:0]  n_ff, n_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_byte_ff;
   logic                  rsp_last_ff;

   // line buffer port signals
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [CHAR_W-1:0] rd_data;

   tle_line_ram #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (char_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // emit handshake: muted once the result budget is spent
   logic              muted, out_free, go;
   logic              emit_req, emit_last, out_load;
   logic [BYTE_W-1:0] emit_byte;
   logic [CNT_W-1:0]  count_m1, count_m2;
   logic              rd_blank;
   logic              accept;
   logic [BYTE_W-1:0] code;
   logic [IDX_W-1:0]  idx_p1;

   assign muted    = (n_ff == RES_MAX);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign go       = muted || out_free;
   assign count_m1 = count_ff - CNT_W'(1);
   assign count_m2 = count_ff - CNT_W'(2);
   assign rd_blank = is_blank(rd_data);
   assign accept   = req_valid && req_ready;
   assign code     = {req_char_in[7] | lit_ff, req_char_in[6:0]};
   assign idx_p1   = idx_ff + IDX_W'(1);

   // next state and outputs
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      count_in  = count_ff;
      lit_in    = lit_ff;
      idx_in    = idx_ff;
      char_in   = char_ff;
      n_in      = n_ff;
      req_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = count_ff[IDX_W-1:0];
      rd_en     = 1'b0;
      rd_addr   = count_m1[IDX_W-1:0];
      emit_req  = 1'b0;
      emit_byte = BS_BYTE;
      emit_last = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               n_in   = '0;
               lit_in = 1'b0;
               idx_in = '0;
               // command decode in priority order
               priority if (code == {1'b0, erase_ff}) begin
                  mode_in = M_ERASE;
                  if (count_ff != '0) state_in = S_RUB1;
               end else if (code == {1'b0, kill_ff}) begin
                  mode_in = M_KILL;
                  if (count_ff != '0) state_in = S_RUB1;
               end else if (code == {1'b0, word_ff}) begin
                  mode_in = M_WORD;
                  if (count_ff != '0) state_in = S_W_RD;
               end else if (code == {1'b0, lit_next_ff}) begin
                  lit_in   = 1'b1;
                  state_in = S_CARET;
               end else if (code == {1'b0, reprint_ff}) begin
                  if (count_ff != '0) state_in = S_P_BS;
               end else begin
                  // plain character; dropped when the line is full
                  char_in = code[CHAR_W-1:0];
                  if (count_ff < DEPTH_CNT) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_ECHO;
                  end
               end
            end
         end

         S_ECHO: begin
            emit_req  = 1'b1;
            emit_byte = {1'b0, char_ff};
            emit_last = 1'b1;
            if (go) state_in = S_IDLE;
         end

         S_CARET: begin
            emit_req  = 1'b1;
            emit_byte = CARET_BYTE;
            if (go) state_in = S_LIT_BS;
         end

         S_LIT_BS: begin
            emit_req  = 1'b1;
            emit_last = 1'b1;
            if (go) state_in = S_IDLE;
         end

         // fetch the character at the end of the line
         S_W_RD: begin
            rd_en    = 1'b1;
            state_in = S_W_CHK;
         end

         // trailing blank gets a bare backspace, else start on the word
         S_W_CHK: begin
            if (rd_blank) begin
               emit_req  = 1'b1;
               emit_last = (count_ff == CNT_W'(1));
               if (go) begin
                  count_in = count_m1;
                  state_in = emit_last ? S_IDLE : S_W_RD;
               end
            end else begin
               state_in = S_RUB1;
            end
         end

         // rubout: prefetch the character below the one being removed
         S_RUB1: begin
            emit_req = 1'b1;
            rd_en    = (count_ff > CNT_W'(1));
            rd_addr  = count_m2[IDX_W-1:0];
            if (go) state_in = S_RUB2;
         end

         S_RUB2: begin
            emit_req  = 1'b1;
            emit_byte = SP_BYTE;
            if (go) state_in = S_RUB3;
         end

         S_RUB3: begin
            emit_req  = 1'b1;
            emit_last = (count_ff == CNT_W'(1)) || (mode_ff == M_ERASE) ||
                        ((mode_ff == M_WORD) && rd_blank);
            if (go) begin
               count_in = count_m1;
               state_in = emit_last ? S_IDLE : S_RUB1;
            end
         end

         // reprint: backspaces over the line
         S_P_BS: begin
            emit_req = 1'b1;
            if (go) begin
               if (CNT_W'(idx_ff) == count_m1) begin
                  idx_in   = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_P_CH;
               end else begin
                  idx_in = idx_p1;
               end
            end
         end

         // reprint: stored characters, next one read on each advance
         S_P_CH: begin
            emit_req  = 1'b1;
            emit_byte = {1'b0, rd_data};
            emit_last = (CNT_W'(idx_ff) == count_m1);
            if (go) begin
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in  = idx_p1;
                  rd_en   = 1'b1;
                  rd_addr = idx_p1;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (emit_req && !muted && out_free) begin
         n_in = n_ff + RES_CNT_W'(1);
      end
   end

   assign out_load = emit_req && !muted && out_free;

   // output register handshake
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         lit_ff       <= 1'b0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lit_ff       <= lit_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      if (out_load) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last || (n_ff == RES_MAX - RES_CNT_W'(1));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_echo_byte = rsp_byte_ff;
   assign rsp_last_echo = rsp_last_ff;

   // line count never passes the buffer depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("line count beyond buffer depth");

   // no request emits more than the result budget
   a_result_budget: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RES_MAX)
      else $error("echo byte budget exceeded");

   // nothing is loaded for output while waiting for a request
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !out_load)
      else $error("echo byte produced while idle");

   // a buffer write only happens on an accepted plain character
   a_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (accept && (state_in == S_ECHO)))
      else $error("line buffer written outside a plain character");

endmodule
`default_nettype wire
